@@ rtl/button_tap_and_hold_detector_assert.svh @@
// ---------------------------------------------------------------------------
// button_tap_and_hold_detector_assert.svh
// Assertion macros for the button tap-and-hold detector.
// ---------------------------------------------------------------------------
`ifndef BUTTON_TAP_AND_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_TAP_AND_HOLD_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset
`define BTNTH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define BTNTH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define BTNTH_ASSERT(lbl, prop, msg)
`define BTNTH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/btnth_pkg.sv @@
// ---------------------------------------------------------------------------
// btnth_pkg
// Shared types and constants of the button tap-and-hold detector.
// ---------------------------------------------------------------------------
package btnth_pkg;

    localparam int CFG_W  = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_TAP_WIN  = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] TAP_WIN_RST  = 16'd300;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] hold_time;
        logic [CFG_W-1:0] tap_window;
    } t_btnth_cfg;

    typedef struct packed {
        logic is_down;
        logic press_pulse;
        logic release_pulse;
        logic single_tap_pulse;
        logic double_tap_pulse;
        logic hold_pulse;
    } t_btnth_result;

endpackage

@@ rtl/button_tap_and_hold_detector.sv @@
// ---------------------------------------------------------------------------
// button_tap_and_hold_detector
// Debounced button with press, release, tap and long-press pulses.
//
//   channel   direction  handshake               payload
//   sample    in         i_in_valid/o_in_stall   i_pin_level
//   result    out        o_out_valid/i_out_stall o_is_down, o_*_pulse
//   config    in         APB psel/penable/pready paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled; an accepted item is held in
// the input register and moves into the result register once that register is
// free (input register, then result register).
// The state update runs as the item moves from input to result register.
// Reset (synchronous) puts the button state at idle; registers go to 50/1000/300.
// Output stall holds the result register and then backs up the input register.
// ---------------------------------------------------------------------------
module button_tap_and_hold_detector #(
    parameter int TIME_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_pin_level,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_is_down,
    output logic                         o_press_pulse,
    output logic                         o_release_pulse,
    output logic                         o_single_tap_pulse,
    output logic                         o_double_tap_pulse,
    output logic                         o_hold_pulse,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [btnth_pkg::ADDR_W-1:0] paddr,
    input  logic [btnth_pkg::DATA_W-1:0] pwdata,
    output logic [btnth_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    `include "button_tap_and_hold_detector_assert.svh"

    btnth_pkg::t_btnth_cfg    cfg;
    btnth_pkg::t_btnth_result step_res;
    btnth_pkg::t_btnth_result r_res;

    logic r_in_valid, r_in_level, r_out_valid;
    logic out_free, fire, in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    btnth_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    btnth_state #(
        .TIME_BITS (TIME_BITS)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire),
        .i_level (r_in_level),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_level <= i_pin_level;
        end
        if (fire) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_is_down          = r_res.is_down;
    assign o_press_pulse      = r_res.press_pulse;
    assign o_release_pulse    = r_res.release_pulse;
    assign o_single_tap_pulse = r_res.single_tap_pulse;
    assign o_double_tap_pulse = r_res.double_tap_pulse;
    assign o_hold_pulse       = r_res.hold_pulse;

    `BTNTH_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `BTNTH_ASSERT(a_no_dbl_tap, !(o_out_valid && o_double_tap_pulse), "double tap seen")
    `BTNTH_ASSERT(a_pr_excl, !(o_out_valid && o_press_pulse && o_release_pulse), "both edges")
    `BTNTH_ASSERT(a_press_down, (o_out_valid && o_press_pulse) |-> o_is_down, "press not down")
    `BTNTH_ASSERT(a_tap_rel, (o_out_valid && o_single_tap_pulse) |-> o_release_pulse, "stray tap")

endmodule

@@ rtl/btnth_cfg.sv @@
// ---------------------------------------------------------------------------
// btnth_cfg
// APB register file: debounce time, hold time and tap window.
// ---------------------------------------------------------------------------
module btnth_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btnth_pkg::ADDR_W-1:0]  paddr,
    input  logic [btnth_pkg::DATA_W-1:0]  pwdata,
    output logic [btnth_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output btnth_pkg::t_btnth_cfg         o_cfg
);

    btnth_pkg::t_btnth_cfg r_cfg;
    logic [1:0]            reg_idx;
    logic                  wr_en;
    logic [btnth_pkg::CFG_W-1:0] rd_val;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= btnth_pkg::DEBOUNCE_RST;
            r_cfg.hold_time     <= btnth_pkg::HOLD_RST;
            r_cfg.tap_window    <= btnth_pkg::TAP_WIN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                btnth_pkg::REG_DEBOUNCE: begin
                    r_cfg.debounce_time <= pwdata[btnth_pkg::CFG_W-1:0];
                end
                btnth_pkg::REG_HOLD: begin
                    r_cfg.hold_time <= pwdata[btnth_pkg::CFG_W-1:0];
                end
                btnth_pkg::REG_TAP_WIN: begin
                    r_cfg.tap_window <= pwdata[btnth_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            btnth_pkg::REG_DEBOUNCE: rd_val = r_cfg.debounce_time;
            btnth_pkg::REG_HOLD:     rd_val = r_cfg.hold_time;
            btnth_pkg::REG_TAP_WIN:  rd_val = r_cfg.tap_window;
            default:                 rd_val = '0;
        endcase
    end

    assign prdata = {{(btnth_pkg::DATA_W - btnth_pkg::CFG_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

@@ rtl/btnth_state.sv @@
// ---------------------------------------------------------------------------
// btnth_state
// Debounce, press timing and tap state; one update per processed item.
// ---------------------------------------------------------------------------
module btnth_state #(
    parameter int TIME_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic                     i_level,
    input  btnth_pkg::t_btnth_cfg    i_cfg,
    output btnth_pkg::t_btnth_result o_res
);

    // compare width covers both counters and 16-bit registers
    localparam int CMP_W = (TIME_BITS > btnth_pkg::CFG_W) ? TIME_BITS : btnth_pkg::CFG_W;

    logic [TIME_BITS-1:0] r_since_change, r_since_press, r_since_tap;
    logic [TIME_BITS-1:0] n_since_change, n_since_press, n_since_tap;
    logic                 r_held, r_hold_done, r_tap_pending;
    logic                 n_held, n_hold_done, n_tap_pending;

    logic [TIME_BITS-1:0] aged_change, aged_press, aged_tap;
    logic                 chg, press, rel, dbl, single, hold, hd_pre;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
        sat_inc = (&t) ? t : t + TIME_BITS'(1);
    endfunction

    always_comb begin
        aged_change = sat_inc(r_since_change);
        aged_press  = sat_inc(r_since_press);
        aged_tap    = sat_inc(r_since_tap);

        // held doubles as the debounced level
        chg   = (i_level != r_held) &&
                (CMP_W'(aged_change) >= CMP_W'(i_cfg.debounce_time));
        press = chg && i_level;
        rel   = chg && !i_level;
        dbl   = press && r_tap_pending &&
                (CMP_W'(aged_tap) <= CMP_W'(i_cfg.tap_window));
        single = rel && r_tap_pending;

        n_since_change = chg   ? '0 : aged_change;
        n_since_press  = press ? '0 : aged_press;
        n_since_tap    = press ? '0 : aged_tap;

        if (press) begin
            n_tap_pending = !dbl;
        end else if (rel) begin
            n_tap_pending = 1'b0;
        end else begin
            n_tap_pending = r_tap_pending;
        end

        n_held = chg ? i_level : r_held;
        hd_pre = press ? 1'b0 : r_hold_done;
        hold   = n_held && !hd_pre &&
                 (CMP_W'(n_since_press) >= CMP_W'(i_cfg.hold_time));
        n_hold_done = hd_pre || hold;

        o_res.is_down          = n_held;
        o_res.press_pulse      = press;
        o_res.release_pulse    = rel;
        o_res.single_tap_pulse = single;
        o_res.double_tap_pulse = dbl;
        o_res.hold_pulse       = hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_change <= '1;
            r_since_press  <= '0;
            r_since_tap    <= '0;
            r_held         <= 1'b0;
            r_hold_done    <= 1'b0;
            r_tap_pending  <= 1'b0;
        end else if (i_step) begin
            r_since_change <= n_since_change;
            r_since_press  <= n_since_press;
            r_since_tap    <= n_since_tap;
            r_held         <= n_held;
            r_hold_done    <= n_hold_done;
            r_tap_pending  <= n_tap_pending;
        end
    end

endmodule

@@ tb/sv/tb_button_tap_and_hold_detector.sv @@
// ----------------------------------------------------------------------------
// tb_button_tap_and_hold_detector
// Self-checking bench for the debounced button tap/hold detector.
// A short scripted sequence covers reset state, zero and full-scale register
// settings and the debounce, tap and hold paths. Randomized gesture phases
// follow under several register settings, one of them with no idling, then a
// closing press under full-scale hold and tap window and a release against a
// full-scale debounce. Scripted rows with a fixed result are checked against it;
// all other result items against a cycle-free bench model of the button state.
// ----------------------------------------------------------------------------
module tb_button_tap_and_hold_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS   = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int GAP_PCT     = 17;
    localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                         i_clk;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    logic                         i_pin_level = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_is_down;
    logic                         o_press_pulse;
    logic                         o_release_pulse;
    logic                         o_single_tap_pulse;
    logic                         o_double_tap_pulse;
    logic                         o_hold_pulse;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [btnth_pkg::ADDR_W-1:0] paddr       = '0;
    logic [btnth_pkg::DATA_W-1:0] pwdata      = '0;
    logic [btnth_pkg::DATA_W-1:0] prdata;
    logic                         pready;

    button_tap_and_hold_detector #(
        .TIME_BITS (TIME_BITS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_pin_level        (i_pin_level),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_is_down          (o_is_down),
        .o_press_pulse      (o_press_pulse),
        .o_release_pulse    (o_release_pulse),
        .o_single_tap_pulse (o_single_tap_pulse),
        .o_double_tap_pulse (o_double_tap_pulse),
        .o_hold_pulse       (o_hold_pulse),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Button model state
    // ------------------------------------------------------------------------
    btnth_pkg::t_btnth_cfg knobs;
    logic                  level_q;
    logic [TIME_BITS-1:0]  since_chg;
    logic [TIME_BITS-1:0]  since_prs;
    logic [TIME_BITS-1:0]  since_tp;
    logic                  is_held;
    logic                  hold_seen;
    logic                  tap_armed;

    btnth_pkg::t_btnth_result button_q[$];
    int                       mismatches = 0;
    bit                       no_gaps    = 1'b0;
    int                       quiet_cycles = 0;

    function automatic logic [TIME_BITS-1:0] aged(input logic [TIME_BITS-1:0] t);
        return (t == TIME_TOP) ? t : t + 1'b1;
    endfunction

    // One millisecond tick of the button state; returns that tick's pulses.
    function automatic btnth_pkg::t_btnth_result tick_button(input logic pin);
        btnth_pkg::t_btnth_result r;
        r = '0;
        since_chg = aged(since_chg);
        since_prs = aged(since_prs);
        since_tp  = aged(since_tp);
        if (pin != level_q && since_chg >= knobs.debounce_time) begin
            level_q   = pin;
            since_chg = '0;
            if (pin) begin
                since_prs     = '0;
                is_held       = 1'b1;
                hold_seen     = 1'b0;
                r.press_pulse = 1'b1;
                // tap rule as specified: a release always disarms in between
                if (tap_armed && since_tp <= knobs.tap_window) begin
                    r.double_tap_pulse = 1'b1;
                    tap_armed          = 1'b0;
                end else begin
                    tap_armed = 1'b1;
                end
                since_tp = '0;
            end else begin
                is_held         = 1'b0;
                r.release_pulse = 1'b1;
                if (tap_armed) begin
                    r.single_tap_pulse = 1'b1;
                    tap_armed          = 1'b0;
                end
            end
        end
        if (is_held && !hold_seen && since_prs >= knobs.hold_time) begin
            hold_seen    = 1'b1;
            r.hold_pulse = 1'b1;
        end
        r.is_down = is_held;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Sample channel driver
    // ------------------------------------------------------------------------
    task automatic push_sample(input logic pin, input logic typed,
                               input btnth_pkg::t_btnth_result fixed);
        btnth_pkg::t_btnth_result want;
        while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
            i_in_valid  <= 1'b0;
            i_pin_level <= 1'($urandom);
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= pin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = tick_button(pin);
        button_q.push_back(typed ? fixed : want);
    endtask

    // Stop sending and wait for every result item to come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (button_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write followed by a readback of the same register.
    task automatic write_reg(input logic [1:0] idx,
                             input logic [btnth_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= btnth_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            btnth_pkg::REG_DEBOUNCE: knobs.debounce_time = value;
            btnth_pkg::REG_HOLD:     knobs.hold_time     = value;
            btnth_pkg::REG_TAP_WIN:  knobs.tap_window    = value;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[btnth_pkg::CFG_W-1:0] !== value)
            flag_error($sformatf("register %0d readback: expected %h, got %h",
                                 idx, value, prdata[btnth_pkg::CFG_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly clean press/release runs sized around the current thresholds,
    // with bursts of contact bounce mixed in.
    task automatic run_phase(input int db, input int hold, input int tap, input int items);
        int   left;
        int   run;
        int   span;
        int   near;
        logic lvl;
        settle();
        write_reg(btnth_pkg::REG_DEBOUNCE, btnth_pkg::CFG_W'(db));
        write_reg(btnth_pkg::REG_HOLD, btnth_pkg::CFG_W'(hold));
        write_reg(btnth_pkg::REG_TAP_WIN, btnth_pkg::CFG_W'(tap));
        span = db + hold + tap + 8;
        if (span > 300) span = 300;
        near = (db + 3 < span) ? db + 3 : span;
        left = items;
        lvl  = 1'($urandom);
        while (left > 0) begin
            if ($urandom_range(99) < 80) begin
                lvl = !lvl;
                run = $urandom_range(1) ? $urandom_range(1, near) : $urandom_range(1, span);
                repeat (run) push_sample(lvl, 1'b0, '0);
            end else begin
                run = $urandom_range(1, 8);
                repeat (run) push_sample(1'($urandom), 1'b0, '0);
            end
            left -= run;
        end
    endtask

    // ------------------------------------------------------------------------
    // Scripted opening sequence
    // ------------------------------------------------------------------------
    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [1:0]                    reg_idx;
        logic [btnth_pkg::CFG_W-1:0]   value;
        logic                          pin;
        logic                          typed;
        btnth_pkg::t_btnth_result      result;
    } t_script_row;

    localparam btnth_pkg::t_btnth_result UP_QUIET   = '0;
    localparam btnth_pkg::t_btnth_result DOWN_QUIET = '{is_down: 1'b1, default: 1'b0};
    localparam btnth_pkg::t_btnth_result PRESSED    = '{is_down: 1'b1, press_pulse: 1'b1,
                                                        default: 1'b0};
    localparam btnth_pkg::t_btnth_result TAP_UP     = '{release_pulse: 1'b1,
                                                        single_tap_pulse: 1'b1,
                                                        default: 1'b0};
    localparam btnth_pkg::t_btnth_result PRESS_HOLD = '{is_down: 1'b1, press_pulse: 1'b1,
                                                        hold_pulse: 1'b1, default: 1'b0};

    localparam int N_ROWS = 32;
    localparam t_script_row SCRIPT [N_ROWS] = '{
        // reset values 50/1000/300; change counter starts saturated
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, PRESSED},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, DOWN_QUIET},
        // all zero: instant accept, hold fires with the press
        '{ROW_WRITE,  btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_WRITE,  btnth_pkg::REG_HOLD,     16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_WRITE,  btnth_pkg::REG_TAP_WIN,  16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, TAP_UP},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, PRESS_HOLD},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, DOWN_QUIET},
        // full scale: release blocked by debounce
        '{ROW_WRITE,  btnth_pkg::REG_DEBOUNCE, 16'hffff, 1'b0, 1'b0, UP_QUIET},
        '{ROW_WRITE,  btnth_pkg::REG_HOLD,     16'hffff, 1'b0, 1'b0, UP_QUIET},
        '{ROW_WRITE,  btnth_pkg::REG_TAP_WIN,  16'hffff, 1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, DOWN_QUIET},
        // short thresholds: bounce rejection, tap and hold
        '{ROW_WRITE,  btnth_pkg::REG_DEBOUNCE, 16'd3,    1'b0, 1'b0, UP_QUIET},
        '{ROW_WRITE,  btnth_pkg::REG_HOLD,     16'd6,    1'b0, 1'b0, UP_QUIET},
        '{ROW_WRITE,  btnth_pkg::REG_TAP_WIN,  16'd4,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, UP_QUIET},
        '{ROW_SAMPLE, btnth_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, UP_QUIET}
    };

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        knobs     = '{debounce_time: btnth_pkg::DEBOUNCE_RST,
                      hold_time: btnth_pkg::HOLD_RST,
                      tap_window: btnth_pkg::TAP_WIN_RST};
        level_q   = 1'b0;
        since_chg = TIME_TOP;
        since_prs = '0;
        since_tp  = '0;
        is_held   = 1'b0;
        hold_seen = 1'b0;
        tap_armed = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_WRITE) begin
                settle();
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].value);
            end else begin
                push_sample(SCRIPT[i].pin, SCRIPT[i].typed, SCRIPT[i].result);
            end
        end

        run_phase($urandom_range(0, 3), $urandom_range(0, 20), $urandom_range(0, 15), 300);
        run_phase(0, 0, 0, 200);
        run_phase($urandom_range(5, 15), $urandom_range(30, 120), $urandom_range(10, 60), 350);
        run_phase(65535, 65535, 65535, 120);
        run_phase($urandom_range(0, 2), $urandom_range(1, 8), $urandom_range(0, 5), 300);
        // long stretch with no idling on either side
        no_gaps = 1'b1;
        run_phase(int'(btnth_pkg::DEBOUNCE_RST), int'(btnth_pkg::HOLD_RST),
                  int'(btnth_pkg::TAP_WIN_RST), 350);
        no_gaps = 1'b0;
        run_phase($urandom_range(0, 4), $urandom_range(0, 40), $urandom_range(0, 65535), 300);

        // Press under full-scale hold and tap window, then release against a
        // full-scale debounce.
        settle();
        write_reg(btnth_pkg::REG_DEBOUNCE, '0);
        write_reg(btnth_pkg::REG_HOLD, '1);
        write_reg(btnth_pkg::REG_TAP_WIN, '1);
        repeat (3) push_sample(1'b0, 1'b0, '0);
        repeat (20) push_sample(1'b1, 1'b0, '0);
        settle();
        write_reg(btnth_pkg::REG_DEBOUNCE, '1);
        repeat (5) push_sample(1'b0, 1'b0, '0);
        repeat (5) push_sample(1'b1, 1'b0, '0);

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result channel: random stall and check against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        btnth_pkg::t_btnth_result seen;
        btnth_pkg::t_btnth_result owed;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen = '{o_is_down, o_press_pulse, o_release_pulse,
                         o_single_tap_pulse, o_double_tap_pulse, o_hold_pulse};
                if (button_q.size() == 0) begin
                    flag_error($sformatf("result item %b with nothing expected", seen));
                end else begin
                    owed = button_q.pop_front();
                    if (seen !== owed)
                        flag_error($sformatf(
                            "{down,press,release,single,double,hold} expected %b, got %b",
                            owed, seen));
                end
            end
            i_out_stall <= !no_gaps && ($urandom_range(99) < GAP_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles without any item moving
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ button_tap_and_hold_detector.f @@
+incdir+rtl
rtl/btnth_pkg.sv
rtl/btnth_cfg.sv
rtl/btnth_state.sv
rtl/button_tap_and_hold_detector.sv
tb/sv/tb_button_tap_and_hold_detector.sv
